@@ rtl/core/rss_pkg.sv @@
// Random subset sampler: shared constants, register and request codes,
// result and memory-port structures. No dependencies.
package rss_pkg;

    localparam int MAX_POP    = 1024;
    localparam int IDX_W      = $clog2(MAX_POP);
    localparam int CNT_W      = IDX_W + 1;
    localparam int RAND_W     = 24;
    localparam int PROD_W     = RAND_W + CNT_W;
    localparam int FIFO_DEPTH = 8;
    localparam int FPTR_W     = $clog2(FIFO_DEPTH);
    localparam int FCNT_W     = FPTR_W + 1;
    localparam int APB_AW     = 3;
    localparam int APB_DW     = 32;

    localparam logic REQ_START = 1'b0;
    localparam logic REQ_STEP  = 1'b1;

    localparam logic REG_SAMPLE_COUNT = 1'b0;
    localparam logic REG_POPULATION   = 1'b1;

    typedef struct packed {
        logic [IDX_W-1:0] position;
        logic [IDX_W-1:0] value;
        logic             last;
    } t_result;

    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic [IDX_W-1:0] wr_data;
        logic [IDX_W-1:0] rd_addr_a;
        logic [IDX_W-1:0] rd_addr_b;
    } t_mem_req;

    typedef struct packed {
        logic [1:0] cnt;
        t_result    res0;
        t_result    res1;
    } t_push;

endpackage

@@ rtl/core/rss_if.sv @@
// Random subset sampler: valid/ready channel interfaces for step requests
// and results. Depends on rss_pkg.
interface rss_req_if;
    logic                      valid;
    logic                      ready;
    logic                      req_type;
    logic [rss_pkg::RAND_W-1:0] rand_word;

    modport source (output valid, output req_type, output rand_word, input ready);
    modport sink   (input valid, input req_type, input rand_word, output ready);
endinterface

interface rss_res_if;
    logic                     valid;
    logic                     ready;
    logic [rss_pkg::IDX_W-1:0] position;
    logic [rss_pkg::IDX_W-1:0] value;
    logic                     last;

    modport source (output valid, output position, output value, output last, input ready);
    modport sink   (input valid, input position, input value, input last, output ready);
endinterface

@@ rtl/core/rss_perm_mem.sv @@
// Random subset sampler: permutation store, one write port and two read
// ports with registered read data. Depends on rss_pkg.
module rss_perm_mem (
    input  logic                     i_clk,
    input  rss_pkg::t_mem_req        i_req,
    output logic [rss_pkg::IDX_W-1:0] o_rd_data_a,
    output logic [rss_pkg::IDX_W-1:0] o_rd_data_b
);

    logic [rss_pkg::IDX_W-1:0] r_mem [rss_pkg::MAX_POP];
    logic [rss_pkg::IDX_W-1:0] r_rd_a;
    logic [rss_pkg::IDX_W-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    // read-before-write; the caller forwards same-edge writes
    always_ff @(posedge i_clk) begin
        r_rd_a <= r_mem[i_req.rd_addr_a];
        r_rd_b <= r_mem[i_req.rd_addr_b];
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

@@ rtl/core/rss_result_fifo.sv @@
// Random subset sampler: result queue taking up to two results per cycle
// and handing out one per transaction. Depends on rss_pkg, rss_if.
module rss_result_fifo (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  rss_pkg::t_push            i_push,
    output logic [rss_pkg::FCNT_W-1:0] o_count,
    rss_res_if.source                 o_res
);

    rss_pkg::t_result            r_buf [rss_pkg::FIFO_DEPTH];
    logic [rss_pkg::FPTR_W-1:0]  r_wr_ptr;
    logic [rss_pkg::FPTR_W-1:0]  r_rd_ptr;
    logic [rss_pkg::FCNT_W-1:0]  r_count;
    logic                        w_pop;
    rss_pkg::t_result            w_head;

    assign w_pop = o_res.valid && o_res.ready;

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_buf[r_wr_ptr] <= i_push.res0;
        end
        if (i_push.cnt == 2'd2) begin
            r_buf[r_wr_ptr + rss_pkg::FPTR_W'(1)] <= i_push.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + rss_pkg::FPTR_W'(i_push.cnt);
            r_rd_ptr <= r_rd_ptr + rss_pkg::FPTR_W'(w_pop);
            r_count  <= r_count + rss_pkg::FCNT_W'(i_push.cnt) - rss_pkg::FCNT_W'(w_pop);
        end
    end

    assign w_head         = r_buf[r_rd_ptr];
    assign o_res.valid    = (r_count != '0);
    assign o_res.position = w_head.position;
    assign o_res.value    = w_head.value;
    assign o_res.last     = w_head.last;
    assign o_count        = r_count;

endmodule

@@ rtl/core/random_subset_sampler_core.sv @@
// Random subset sampler top level: APB register file, step control, and
// the permutation store and result queue. Depends on rss_pkg, rss_if,
// rss_perm_mem, rss_result_fifo.
//
// Usage: program sample_count (M, 0x0) and population_size (N, 0x4) over
// APB, then send a start transaction (req_type 0) on i_req followed by step
// transactions (req_type 1), each carrying a 24-bit random fraction.
// With M < N each step visits one index and may select it (ascending order);
// with M >= N the steps run a Fisher-Yates shuffle, one position per step and
// two on the step that reaches position 0. Results leave on o_res with last
// set on the final one of the run. Steps while idle are dropped.
// A step's results pass through the stage register r_s1 and the result queue
// before they appear on o_res.
// Throughput: one step per cycle while o_res is taken at one per cycle; the
// store is read at two ports and written at one per cycle, with same-entry
// writes forwarded. A start in shuffle mode loads the store with 0..N-1,
// one entry per cycle, so i_req is held off until the load is done.
// Reset clears the run to idle, M and N to 1. When o_res stalls, results
// queue in an 8-entry buffer and i_req.ready drops once it nears full.
module random_subset_sampler_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [rss_pkg::APB_AW-1:0] paddr,
    input  logic [rss_pkg::APB_DW-1:0] pwdata,
    output logic [rss_pkg::APB_DW-1:0] prdata,
    output logic                      pready,
    rss_req_if.sink                   i_req,
    rss_res_if.source                 o_res
);

    typedef struct packed {
        logic                      valid;
        logic                      permute;
        logic [1:0]                cnt;
        logic                      wr_en;
        logic [rss_pkg::IDX_W-1:0] wr_addr;
        rss_pkg::t_result          res0;
        rss_pkg::t_result          res1;
    } t_stage;

    logic [rss_pkg::CNT_W-1:0] r_sample_count;
    logic [rss_pkg::CNT_W-1:0] r_population_size;

    logic [rss_pkg::CNT_W-1:0] r_cursor,    n_cursor;
    logic [rss_pkg::CNT_W-1:0] r_remaining, n_remaining;
    logic [rss_pkg::CNT_W-1:0] r_still,     n_still;
    logic [rss_pkg::CNT_W-1:0] r_emitted,   n_emitted;
    logic                      r_permute,   n_permute;
    logic                      r_active,    n_active;
    logic                      r_filling,   n_filling;
    logic [rss_pkg::IDX_W-1:0] r_fill_idx,  n_fill_idx;
    logic [rss_pkg::IDX_W-1:0] r_fill_last, n_fill_last;
    t_stage                    r_s1,        n_s1;

    logic                      r_fwd_a;
    logic                      r_fwd_b;
    logic [rss_pkg::IDX_W-1:0] r_fwd_data;

    logic                       w_cfg_wr;
    logic                       w_in_fire;
    logic                       w_step;
    logic [rss_pkg::CNT_W-1:0]  w_n;
    logic [rss_pkg::CNT_W-1:0]  w_n_m1;
    logic                       w_perm_start;
    logic [rss_pkg::CNT_W-1:0]  w_mul_op;
    logic [rss_pkg::PROD_W-1:0] w_prod;
    logic [rss_pkg::PROD_W-1:0] w_rhs;
    logic                       w_hit;
    logic [rss_pkg::IDX_W-1:0]  w_j;
    logic [rss_pkg::IDX_W-1:0]  w_c;
    logic [rss_pkg::IDX_W-1:0]  w_rd_a;
    logic [rss_pkg::IDX_W-1:0]  w_rd_b;
    logic [rss_pkg::IDX_W-1:0]  w_mem_a;
    logic [rss_pkg::IDX_W-1:0]  w_mem_b;
    logic [rss_pkg::IDX_W-1:0]  w_data_a;
    logic [rss_pkg::IDX_W-1:0]  w_data_b;
    logic                       w_s1_wr;
    logic [1:0]                 w_s1_cnt;
    logic [rss_pkg::FCNT_W-1:0] w_fifo_cnt;
    rss_pkg::t_mem_req          w_mem_req;
    rss_pkg::t_push             w_push;

    // ---------------- configuration port ----------------
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign pready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_count    <= rss_pkg::CNT_W'(1);
            r_population_size <= rss_pkg::CNT_W'(1);
        end else if (w_cfg_wr) begin
            unique case (paddr[2])
                rss_pkg::REG_SAMPLE_COUNT: r_sample_count    <= pwdata[rss_pkg::CNT_W-1:0];
                rss_pkg::REG_POPULATION:   r_population_size <= pwdata[rss_pkg::CNT_W-1:0];
            endcase
        end
    end

    assign prdata = {{(rss_pkg::APB_DW - rss_pkg::CNT_W){1'b0}},
                     (paddr[2] == rss_pkg::REG_POPULATION) ? r_population_size
                                                           : r_sample_count};

    // ---------------- request side ----------------
    assign w_s1_cnt   = r_s1.valid ? r_s1.cnt : 2'd0;
    assign i_req.ready = !r_filling &&
        ((w_fifo_cnt + rss_pkg::FCNT_W'(w_s1_cnt))
            <= rss_pkg::FCNT_W'(rss_pkg::FIFO_DEPTH - 2));

    assign w_in_fire = i_req.valid && i_req.ready;
    assign w_step    = w_in_fire && (i_req.req_type == rss_pkg::REQ_STEP) && r_active;

    assign w_n = (r_population_size > rss_pkg::CNT_W'(rss_pkg::MAX_POP))
               ? rss_pkg::CNT_W'(rss_pkg::MAX_POP) : r_population_size;
    assign w_n_m1       = w_n - rss_pkg::CNT_W'(1);
    assign w_perm_start = (r_sample_count >= w_n);

    // shared multiplier: draw scaling in shuffle mode, acceptance test in selection
    assign w_mul_op = r_permute ? (r_cursor + rss_pkg::CNT_W'(1)) : r_remaining;
    assign w_prod   = {{rss_pkg::CNT_W{1'b0}}, i_req.rand_word}
                    * {{rss_pkg::RAND_W{1'b0}}, w_mul_op};
    assign w_rhs    = {r_still, {rss_pkg::RAND_W{1'b0}}};
    assign w_hit    = (r_still != '0) && (w_prod < w_rhs);
    assign w_j      = w_prod[rss_pkg::RAND_W +: rss_pkg::IDX_W];
    assign w_c      = r_cursor[rss_pkg::IDX_W-1:0];

    always_comb begin
        n_cursor    = r_cursor;
        n_remaining = r_remaining;
        n_still     = r_still;
        n_emitted   = r_emitted;
        n_permute   = r_permute;
        n_active    = r_active;
        n_filling   = r_filling;
        n_fill_idx  = r_fill_idx;
        n_fill_last = r_fill_last;
        n_s1        = '0;
        w_rd_a      = '0;
        w_rd_b      = w_c;

        if (r_filling) begin
            if (r_fill_idx == r_fill_last) begin
                n_filling = 1'b0;
            end else begin
                n_fill_idx = r_fill_idx + rss_pkg::IDX_W'(1);
            end
        end

        if (w_in_fire && (i_req.req_type == rss_pkg::REQ_START)) begin
            n_cursor    = '0;
            n_remaining = w_n;
            n_still     = r_sample_count;
            n_emitted   = '0;
            if (w_n == '0) begin
                n_active  = 1'b0;
                n_permute = 1'b0;
            end else begin
                n_active  = 1'b1;
                n_permute = w_perm_start;
                if (w_perm_start) begin
                    n_cursor    = w_n_m1;
                    n_filling   = 1'b1;
                    n_fill_idx  = '0;
                    n_fill_last = w_n_m1[rss_pkg::IDX_W-1:0];
                end
            end
        end else if (w_step) begin
            n_s1.valid   = 1'b1;
            n_s1.permute = r_permute;
            if (!r_permute) begin
                n_s1.res0.position = r_emitted[rss_pkg::IDX_W-1:0];
                n_s1.res0.value    = r_cursor[rss_pkg::IDX_W-1:0];
                n_s1.res0.last     = (r_still == rss_pkg::CNT_W'(1));
                if (w_hit) begin
                    n_s1.cnt  = 2'd1;
                    n_still   = r_still - rss_pkg::CNT_W'(1);
                    n_emitted = r_emitted + rss_pkg::CNT_W'(1);
                end
                n_cursor = r_cursor + rss_pkg::CNT_W'(1);
                if (r_remaining != '0) begin
                    n_remaining = r_remaining - rss_pkg::CNT_W'(1);
                end
                if ((r_remaining <= rss_pkg::CNT_W'(1)) ||
                    (w_hit && (r_still == rss_pkg::CNT_W'(1)))) begin
                    n_active = 1'b0;
                end
            end else begin
                n_s1.res0.position = w_c;
                n_s1.res1.position = '0;
                n_s1.res1.last     = 1'b1;
                if (w_c == '0) begin
                    // single remaining position
                    w_rd_a         = '0;
                    n_s1.cnt       = 2'd1;
                    n_s1.res0.last = 1'b1;
                    n_active       = 1'b0;
                    n_emitted      = r_emitted + rss_pkg::CNT_W'(1);
                end else if (w_c == rss_pkg::IDX_W'(1)) begin
                    // final swap: emit both positions, no write-back
                    w_rd_a    = w_j;
                    w_rd_b    = (w_j == '0) ? rss_pkg::IDX_W'(1) : '0;
                    n_s1.cnt  = 2'd2;
                    n_active  = 1'b0;
                    n_emitted = r_emitted + rss_pkg::CNT_W'(2);
                end else begin
                    // entry c is final; only entry j takes the old store[c]
                    w_rd_a       = w_j;
                    w_rd_b       = w_c;
                    n_s1.cnt     = 2'd1;
                    n_s1.wr_en   = 1'b1;
                    n_s1.wr_addr = w_j;
                    n_cursor     = r_cursor - rss_pkg::CNT_W'(1);
                    n_emitted    = r_emitted + rss_pkg::CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor    <= '0;
            r_remaining <= '0;
            r_still     <= '0;
            r_emitted   <= '0;
            r_permute   <= 1'b0;
            r_active    <= 1'b0;
            r_filling   <= 1'b0;
            r_fill_idx  <= '0;
            r_fill_last <= '0;
            r_s1        <= '0;
        end else begin
            r_cursor    <= n_cursor;
            r_remaining <= n_remaining;
            r_still     <= n_still;
            r_emitted   <= n_emitted;
            r_permute   <= n_permute;
            r_active    <= n_active;
            r_filling   <= n_filling;
            r_fill_idx  <= n_fill_idx;
            r_fill_last <= n_fill_last;
            r_s1        <= n_s1;
        end
    end

    // ---------------- store access and forwarding ----------------
    assign w_s1_wr  = r_s1.valid && r_s1.wr_en;
    assign w_data_a = r_fwd_a ? r_fwd_data : w_mem_a;
    assign w_data_b = r_fwd_b ? r_fwd_data : w_mem_b;

    always_ff @(posedge i_clk) begin
        r_fwd_a    <= w_s1_wr && (w_rd_a == r_s1.wr_addr);
        r_fwd_b    <= w_s1_wr && (w_rd_b == r_s1.wr_addr);
        r_fwd_data <= w_data_b;
    end

    assign w_mem_req.wr_en     = w_s1_wr || r_filling;
    assign w_mem_req.wr_addr   = w_s1_wr ? r_s1.wr_addr : r_fill_idx;
    assign w_mem_req.wr_data   = w_s1_wr ? w_data_b : r_fill_idx;
    assign w_mem_req.rd_addr_a = w_rd_a;
    assign w_mem_req.rd_addr_b = w_rd_b;

    rss_perm_mem u_perm_mem (
        .i_clk       (i_clk),
        .i_req       (w_mem_req),
        .o_rd_data_a (w_mem_a),
        .o_rd_data_b (w_mem_b)
    );

    // ---------------- results ----------------
    always_comb begin
        w_push            = '0;
        w_push.cnt        = w_s1_cnt;
        w_push.res0       = r_s1.res0;
        w_push.res1       = r_s1.res1;
        if (r_s1.permute) begin
            w_push.res0.value = w_data_a;
        end
        w_push.res1.value = w_data_b;
    end

    rss_result_fifo u_result_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_count (w_fifo_cnt),
        .o_res   (o_res)
    );

    // ---------------- assertions ----------------
    a_queue_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fifo_cnt + rss_pkg::FCNT_W'(w_push.cnt))
            <= rss_pkg::FCNT_W'(rss_pkg::FIFO_DEPTH))
        else $error("result queue overrun");

    a_fill_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_filling |-> !w_s1_wr)
        else $error("store load collides with swap write-back");

    a_fill_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_filling |-> (r_active && r_permute))
        else $error("store load outside an active shuffle run");

endmodule

@@ sim/rss_pick_checker.sv @@
// Result checker for the random subset sampler: follows APB register writes
// and request transactions, predicts each pick and compares it with the
// result transactions. Depends on rss_pkg and rss_if.
`timescale 1ns / 1ps
module rss_pick_checker
    import rss_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    rss_req_if                req_mon,
    rss_res_if                res_mon,
    output int                o_errors,
    output int                o_pending
);

    logic [CNT_W-1:0] cfg_sample;
    logic [CNT_W-1:0] cfg_pop;
    logic [CNT_W-1:0] cursor;
    logic [CNT_W-1:0] left_to_visit;
    logic [CNT_W-1:0] left_to_pick;
    logic [CNT_W-1:0] picked;
    logic             perm_run;
    logic             running;
    logic [IDX_W-1:0] deck [MAX_POP];
    t_result          picks_due [$];
    int               err_count = 0;

    function automatic t_result make_pick(input logic [IDX_W-1:0] pos,
                                          input logic [IDX_W-1:0] val,
                                          input logic             fin);
        t_result p;
        p.position = pos;
        p.value    = val;
        p.last     = fin;
        return p;
    endfunction

    task automatic begin_run();
        logic [CNT_W-1:0] n;
        n = (cfg_pop > CNT_W'(MAX_POP)) ? CNT_W'(MAX_POP) : cfg_pop;
        cursor        = '0;
        left_to_visit = n;
        left_to_pick  = cfg_sample;
        picked        = '0;
        if (n == 0) begin
            running  = 1'b0;
            perm_run = 1'b0;
        end else begin
            running  = 1'b1;
            perm_run = (cfg_sample >= n);
            if (perm_run) begin
                for (int i = 0; i < MAX_POP; i++) begin
                    if (i < n) deck[i] = IDX_W'(i);
                end
                cursor = n - 1'b1;
            end
        end
    endtask

    task automatic select_step(input logic [RAND_W-1:0] r);
        logic [63:0] lhs;
        logic [63:0] rhs;
        logic        hit;
        lhs = 64'(r) * 64'(left_to_visit);
        rhs = 64'(left_to_pick) << RAND_W;
        hit = (left_to_pick != 0) && (lhs < rhs);
        if (hit) begin
            left_to_pick = left_to_pick - 1'b1;
            picks_due.push_back(make_pick(picked[IDX_W-1:0], cursor[IDX_W-1:0],
                                          left_to_pick == 0));
            picked = picked + 1'b1;
        end
        cursor = cursor + 1'b1;
        if (left_to_visit != 0) left_to_visit = left_to_visit - 1'b1;
        if (left_to_visit == 0 || (hit && left_to_pick == 0)) running = 1'b0;
    endtask

    task automatic shuffle_step(input logic [RAND_W-1:0] r);
        logic [CNT_W-1:0] c;
        logic [63:0]      j;
        logic [IDX_W-1:0] tmp;
        c = (cursor >= CNT_W'(MAX_POP)) ? CNT_W'(MAX_POP - 1) : cursor;
        if (c == 0) begin
            picks_due.push_back(make_pick('0, deck[0], 1'b1));
            picked  = picked + 1'b1;
            running = 1'b0;
        end else begin
            j = (64'(r) * 64'(c + 1)) >> RAND_W;
            if (j > 64'(c)) j = 64'(c);
            tmp = deck[j[IDX_W-1:0]];
            deck[j[IDX_W-1:0]] = deck[c[IDX_W-1:0]];
            deck[c[IDX_W-1:0]] = tmp;
            picks_due.push_back(make_pick(c[IDX_W-1:0], deck[c[IDX_W-1:0]], 1'b0));
            picked = picked + 1'b1;
            cursor = c - 1'b1;
            if (cursor == 0) begin
                picks_due.push_back(make_pick('0, deck[0], 1'b1));
                picked  = picked + 1'b1;
                running = 1'b0;
            end
        end
    endtask

    task automatic check_result();
        t_result got;
        t_result want;
        got = make_pick(res_mon.position, res_mon.value, res_mon.last);
        if (picks_due.size() == 0) begin
            err_count++;
            if (err_count <= 200)
                $display("%0t: unexpected result, got position %0d value %0d last %0d",
                         $time, got.position, got.value, got.last);
        end else begin
            want = picks_due.pop_front();
            if (got.position !== want.position || got.value !== want.value ||
                got.last !== want.last) begin
                err_count++;
                if (err_count <= 200)
                    $display({"%0t: result mismatch, expected position %0d value %0d ",
                              "last %0d, got position %0d value %0d last %0d"},
                             $time, want.position, want.value, want.last,
                             got.position, got.value, got.last);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_sample    = CNT_W'(1);
            cfg_pop       = CNT_W'(1);
            cursor        = '0;
            left_to_visit = '0;
            left_to_pick  = '0;
            picked        = '0;
            perm_run      = 1'b0;
            running       = 1'b0;
            picks_due.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_SAMPLE_COUNT) cfg_sample = pwdata[CNT_W-1:0];
                else cfg_pop = pwdata[CNT_W-1:0];
            end
            if (req_mon.valid && req_mon.ready) begin
                if (req_mon.req_type == REQ_START) begin
                    begin_run();
                end else if (running) begin
                    if (perm_run) shuffle_step(req_mon.rand_word);
                    else select_step(req_mon.rand_word);
                end
            end
            if (res_mon.valid && res_mon.ready) check_result();
        end
        o_errors  <= err_count;
        o_pending <= picks_due.size();
    end

endmodule

@@ sim/tb.sv @@
// Testbench top for random_subset_sampler_core: clock, reset, APB register
// setup and request traffic with changing idle rates on both channels.
// Depends on rss_pkg, rss_if, rss_pick_checker and the sampler RTL.
`timescale 1ns / 1ps
module tb;
    import rss_pkg::*;

    localparam int ITEM_TARGET = 1300;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    int                send_idle;
    int                recv_idle;
    int                items_sent;
    int                fail_count;
    int                open_count;

    rss_req_if req_ch ();
    rss_res_if res_ch ();

    random_subset_sampler_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_req   (req_ch),
        .o_res   (res_ch)
    );

    rss_pick_checker pick_check (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .pready    (pready),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .req_mon   (req_ch),
        .res_mon   (res_ch),
        .o_errors  (fail_count),
        .o_pending (open_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            res_ch.ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    initial begin
        #4000000;
        $display("FAILURE");
        $finish;
    end

    function automatic logic [RAND_W-1:0] draw_word();
        case ($urandom_range(9))
            0, 1:    return '0;
            2:       return '1;
            3:       return RAND_W'($urandom_range(255));
            default: return RAND_W'($urandom);
        endcase
    endfunction

    task automatic send_req(input logic kind, input logic [RAND_W-1:0] r, input bit tally);
        if (items_sent < ITEM_TARGET / 3) begin
            send_idle = 23;
            recv_idle = 60;
        end else if (items_sent < 2 * ITEM_TARGET / 3) begin
            send_idle = 60;
            recv_idle = 23;
        end else begin
            send_idle = 0;
            recv_idle = 0;
        end
        if ($urandom_range(99) < send_idle) begin
            req_ch.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle);
        end
        req_ch.valid     <= 1'b1;
        req_ch.req_type  <= kind;
        req_ch.rand_word <= r;
        do @(posedge i_clk); while (!req_ch.ready);
        if (tally) items_sent++;
    endtask

    task automatic write_reg(input logic idx, input logic [CNT_W-1:0] v);
        logic [APB_DW-1:0] noise;
        noise   = $urandom;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= (noise & ~APB_DW'(11'h7FF)) | APB_DW'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // drain all results, then leave room for a store load still in progress
    task automatic settle();
        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (open_count != 0);
        repeat (MAX_POP + 16) @(posedge i_clk);
    endtask

    task automatic run_draws(input logic [CNT_W-1:0] m, input logic [CNT_W-1:0] n);
        int n_eff;
        int full;
        int steps;
        n_eff = (n > MAX_POP) ? MAX_POP : int'(n);
        if (n_eff == 0) full = 1;
        else if (m >= n_eff) full = (n_eff > 1) ? n_eff - 1 : 1;
        else full = n_eff;
        steps = full;
        if (full > 64) steps = $urandom_range(1, 48);
        else if ($urandom_range(99) < 15) steps = $urandom_range(1, full);
        send_req(REQ_START, draw_word(), 1'b1);
        repeat (steps) send_req(REQ_STEP, draw_word(), 1'b1);
        if (steps == full && $urandom_range(99) < 25)
            repeat ($urandom_range(1, 2)) send_req(REQ_STEP, draw_word(), 1'b0);
    endtask

    initial begin
        logic [CNT_W-1:0] m;
        logic [CNT_W-1:0] n;
        int               n_eff;
        int               r;
        int               guard;

        send_idle  = 23;
        recv_idle  = 60;
        items_sent = 0;
        i_rst_n          <= 1'b0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        req_ch.valid     <= 1'b0;
        req_ch.req_type  <= REQ_START;
        req_ch.rand_word <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: idle step, single-member shuffle, zero sample count,
        // early finish, oversized population with restart, empty population, M above N
        send_req(REQ_STEP, '0, 1'b0);
        send_req(REQ_START, draw_word(), 1'b1);
        send_req(REQ_STEP, '1, 1'b1);
        settle();
        write_reg(REG_SAMPLE_COUNT, 11'd0);
        write_reg(REG_POPULATION, 11'd3);
        send_req(REQ_START, draw_word(), 1'b1);
        send_req(REQ_STEP, '0, 1'b1);
        send_req(REQ_STEP, '1, 1'b1);
        send_req(REQ_STEP, '0, 1'b1);
        settle();
        write_reg(REG_SAMPLE_COUNT, 11'd2);
        write_reg(REG_POPULATION, 11'd5);
        send_req(REQ_START, draw_word(), 1'b1);
        send_req(REQ_STEP, '0, 1'b1);
        send_req(REQ_STEP, '0, 1'b1);
        send_req(REQ_STEP, '0, 1'b1);
        settle();
        write_reg(REG_SAMPLE_COUNT, 11'h7FF);
        write_reg(REG_POPULATION, 11'h7FF);
        send_req(REQ_START, draw_word(), 1'b1);
        send_req(REQ_STEP, '1, 1'b1);
        send_req(REQ_STEP, '0, 1'b1);
        send_req(REQ_STEP, 24'h123456, 1'b1);
        send_req(REQ_START, draw_word(), 1'b1);
        send_req(REQ_STEP, '0, 1'b1);
        settle();
        write_reg(REG_POPULATION, 11'd0);
        send_req(REQ_START, draw_word(), 1'b1);
        send_req(REQ_STEP, '1, 1'b1);
        settle();
        write_reg(REG_SAMPLE_COUNT, 11'd5);
        write_reg(REG_POPULATION, 11'd4);
        send_req(REQ_START, draw_word(), 1'b1);
        send_req(REQ_STEP, '1, 1'b1);
        send_req(REQ_STEP, '0, 1'b1);
        send_req(REQ_STEP, 24'h800000, 1'b1);
        settle();

        while (items_sent < ITEM_TARGET) begin
            r = $urandom_range(99);
            if (r < 3) n = 11'd0;
            else if (r < 7) n = 11'd1;
            else if (r < 11) n = 11'h7FF;
            else if (r < 15) n = CNT_W'($urandom_range(65, 2046));
            else if (r < 30) n = CNT_W'($urandom_range(17, 64));
            else n = CNT_W'($urandom_range(2, 16));
            n_eff = (n > MAX_POP) ? MAX_POP : int'(n);
            if (n_eff == 0 || $urandom_range(1) == 0) begin
                r = $urandom_range(4);
                if (r == 0) m = 11'h7FF;
                else if (r == 1) m = n;
                else m = CNT_W'($urandom_range(n_eff, 2047));
            end else begin
                m = ($urandom_range(4) == 0) ? 11'd0 : CNT_W'($urandom_range(0, n_eff - 1));
            end
            if ($urandom_range(1) == 0) begin
                write_reg(REG_SAMPLE_COUNT, m);
                write_reg(REG_POPULATION, n);
            end else begin
                write_reg(REG_POPULATION, n);
                write_reg(REG_SAMPLE_COUNT, m);
            end
            repeat ($urandom_range(1, 4)) run_draws(m, n);
            settle();
        end

        req_ch.valid <= 1'b0;
        guard = 0;
        do begin
            @(posedge i_clk);
            guard++;
        end while (open_count != 0 && guard < 50000);
        repeat (16) @(posedge i_clk);
        if (fail_count == 0 && open_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/rss_pkg.sv
rtl/core/rss_if.sv
rtl/core/rss_perm_mem.sv
rtl/core/rss_result_fifo.sv
rtl/core/random_subset_sampler_core.sv
sim/rss_pick_checker.sv
sim/tb.sv
